// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the receive window.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: hw/rtl/srrw_pkg.sv
// Types and constants of the selective-repeat receive window.
// No dependencies.
`default_nettype none
package srrw_pkg;

  localparam int SRC_ID_W = 4;
  localparam int SEQ_W    = 16;
  localparam int NUM_W    = 17;
  localparam int PAY_W    = 64;
  localparam int OWN_W    = 8;
  localparam int WS_W     = 4;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_FWD  = 2'd2
  } kind_e;

  // configuration register indexes
  localparam logic CFG_WINDOW_SIZE = 1'b0;
  localparam logic CFG_OWN_ID      = 1'b1;

  localparam logic [WS_W-1:0]  WS_RESET  = 4'd8;
  localparam logic [OWN_W-1:0] OWN_RESET = 8'd0;

endpackage
`default_nettype wire

// File: hw/rtl/selective_repeat_receive_window_top.sv
// Per-source selective-repeat receive window with cumulative acknowledgement.
// Forwarded and ahead-of-window acks are registered in the evaluation state; an in-order
// frame releasing buffered frames delivers each one after its registered slot read
// (REL, then EMIT) and acks once the run ends. A new request is taken only when the
// block is idle again, as busy_o shows. Results cannot be stalled. Reset clears all
// windows at once. Depends on srrw_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module selective_repeat_receive_window_top #(
  parameter int WINDOW  = 8,
  parameter int SOURCES = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [0:0]                    cfg_idx_i,
  input  wire logic [srrw_pkg::OWN_W-1:0]    cfg_wdata_i,
  input  wire logic [srrw_pkg::SRC_ID_W-1:0] src_id_i,
  input  wire logic [srrw_pkg::SEQ_W-1:0]    seq_num_i,
  input  wire logic                          crc_ok_i,
  input  wire logic                          is_ack_i,
  input  wire logic [srrw_pkg::SEQ_W-1:0]    ack_in_i,
  input  wire logic                          ends_message_i,
  input  wire logic [srrw_pkg::PAY_W-1:0]    payload_i,
  output logic                               result_valid_o,
  output logic [1:0]                         kind_o,
  output logic [srrw_pkg::SRC_ID_W-1:0]      peer_id_o,
  output logic [srrw_pkg::OWN_W-1:0]         sender_id_o,
  output logic signed [srrw_pkg::NUM_W-1:0]  number_o,
  output logic [srrw_pkg::PAY_W-1:0]         out_payload_o,
  output logic                               out_ends_message_o,
  output logic                               last_result_o
);
  import srrw_pkg::*;

  localparam int SRC_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int DEPTH  = SOURCES * WINDOW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW     = ($clog2(WINDOW + 1) > WS_W) ? $clog2(WINDOW + 1) : WS_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_REL,
    ST_EMIT
  } state_e;

  state_e state_q;

  logic [WS_W-1:0]     win_size_q;
  logic [OWN_W-1:0]    own_id_q;

  logic [SRC_ID_W-1:0] src_q;
  logic [SEQ_W-1:0]    seq_q;
  logic                crc_q;
  logic                is_ack_q;
  logic [SEQ_W-1:0]    ack_in_q;
  logic                ends_q;
  logic [PAY_W-1:0]    pay_q;

  logic [SEQ_W-1:0]    exp_q   [SOURCES];
  logic [SLOT_W-1:0]   eslot_q [SOURCES];
  logic [WINDOW-1:0]   pres_q  [SOURCES];

  logic [NUM_W-1:0]    cur_seq_q;
  logic [SLOT_W-1:0]   cur_slot_q;
  logic [WW-1:0]       cnt_q;

  logic [PAY_W:0]      mem [DEPTH];
  logic [PAY_W:0]      rdata_q;

  // request decode and window check
  logic [SRC_W+SRC_ID_W-1:0] src_wide;
  logic [SRC_W-1:0]          sidx;
  logic                      src_ok;
  logic [WW-1:0]             ws_ext;
  logic [WW-1:0]             w_eff;
  logic [SEQ_W-1:0]          exp_cur;
  logic [SLOT_W-1:0]         eslot_cur;
  logic [NUM_W-1:0]          off;
  logic                      in_win;
  logic [SLOT_W:0]           slot_sum;
  logic [SLOT_W-1:0]         wr_slot;
  logic                      rel_go;
  logic [SLOT_W-1:0]         next_slot;
  logic                      mem_we;
  logic [ADDR_W-1:0]         waddr;
  logic                      mem_re;
  logic [ADDR_W-1:0]         raddr;

  function automatic logic [ADDR_W-1:0] slot_addr(logic [SRC_W-1:0] s, logic [SLOT_W-1:0] sl);
    slot_addr = ADDR_W'(ADDR_W'(s) * ADDR_W'(WINDOW)) + ADDR_W'(sl);
  endfunction

  always_comb begin
    src_wide  = {{SRC_W{1'b0}}, src_q};
    sidx      = src_wide[SRC_W-1:0];
    src_ok    = src_wide < (SRC_W + SRC_ID_W)'(SOURCES);
    ws_ext    = WW'(win_size_q);
    w_eff     = (ws_ext > WW'(WINDOW)) ? WW'(WINDOW) : ws_ext;
    exp_cur   = exp_q[sidx];
    eslot_cur = eslot_q[sidx];
    off       = {1'b0, seq_q} - {1'b0, exp_cur};
    in_win    = (seq_q >= exp_cur) && (off < NUM_W'(w_eff));
    slot_sum  = {1'b0, eslot_cur} + {1'b0, off[SLOT_W-1:0]};
    wr_slot   = (slot_sum >= (SLOT_W + 1)'(WINDOW)) ?
                SLOT_W'(slot_sum - (SLOT_W + 1)'(WINDOW)) : slot_sum[SLOT_W-1:0];
    rel_go    = (cnt_q < w_eff) && !cur_seq_q[NUM_W-1] && pres_q[sidx][cur_slot_q];
    next_slot = (cur_slot_q == SLOT_W'(WINDOW - 1)) ? '0 : cur_slot_q + 1'b1;
    mem_we    = (state_q == ST_EVAL) && crc_q && !is_ack_q && src_ok && in_win;
    waddr     = slot_addr(sidx, wr_slot);
    mem_re    = (state_q == ST_REL) && rel_go;
    raddr     = slot_addr(sidx, cur_slot_q);
  end

  assign busy_o = (state_q != ST_IDLE);

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= {ends_q, pay_q};
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= ST_IDLE;
      win_size_q         <= WS_RESET;
      own_id_q           <= OWN_RESET;
      src_q              <= '0;
      seq_q              <= '0;
      crc_q              <= 1'b0;
      is_ack_q           <= 1'b0;
      ack_in_q           <= '0;
      ends_q             <= 1'b0;
      pay_q              <= '0;
      for (int i = 0; i < SOURCES; i++) begin
        exp_q[i]   <= '0;
        eslot_q[i] <= '0;
        pres_q[i]  <= '0;
      end
      cur_seq_q          <= '0;
      cur_slot_q         <= '0;
      cnt_q              <= '0;
      result_valid_o     <= 1'b0;
      kind_o             <= KIND_DATA;
      peer_id_o          <= '0;
      sender_id_o        <= '0;
      number_o           <= '0;
      out_payload_o      <= '0;
      out_ends_message_o <= 1'b0;
      last_result_o      <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WINDOW_SIZE: win_size_q <= cfg_wdata_i[WS_W-1:0];
          CFG_OWN_ID:      own_id_q   <= cfg_wdata_i;
          default:         ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            src_q    <= src_id_i;
            seq_q    <= seq_num_i;
            crc_q    <= crc_ok_i;
            is_ack_q <= is_ack_i;
            ack_in_q <= ack_in_i;
            ends_q   <= ends_message_i;
            pay_q    <= payload_i;
            state_q  <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state_q            <= ST_IDLE;
          peer_id_o          <= src_q;
          out_payload_o      <= '0;
          out_ends_message_o <= 1'b0;
          last_result_o      <= 1'b1;
          if (!crc_q) begin
            // drop: bad checksum
          end else if (is_ack_q) begin
            result_valid_o <= 1'b1;
            kind_o         <= KIND_FWD;
            sender_id_o    <= '0;
            number_o       <= {1'b0, ack_in_q};
          end else if (src_ok && in_win) begin
            pres_q[sidx][wr_slot] <= 1'b1;
            if (off == '0) begin
              cur_seq_q  <= {1'b0, exp_cur};
              cur_slot_q <= eslot_cur;
              cnt_q      <= '0;
              state_q    <= ST_REL;
            end else begin
              result_valid_o <= 1'b1;
              kind_o         <= KIND_ACK;
              sender_id_o    <= own_id_q;
              number_o       <= {1'b0, exp_cur} - NUM_W'(1);
            end
          end
        end
        ST_REL: begin
          if (rel_go) begin
            state_q <= ST_EMIT;
          end else begin
            // end of run: acknowledge and advance the window
            result_valid_o     <= 1'b1;
            kind_o             <= KIND_ACK;
            peer_id_o          <= src_q;
            sender_id_o        <= own_id_q;
            number_o           <= cur_seq_q - NUM_W'(1);
            out_payload_o      <= '0;
            out_ends_message_o <= 1'b0;
            last_result_o      <= 1'b1;
            exp_q[sidx]        <= cur_seq_q[NUM_W-1] ? {SEQ_W{1'b1}} : cur_seq_q[SEQ_W-1:0];
            eslot_q[sidx]      <= cur_slot_q;
            state_q            <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          result_valid_o               <= 1'b1;
          kind_o                       <= KIND_DATA;
          peer_id_o                    <= src_q;
          sender_id_o                  <= '0;
          number_o                     <= cur_seq_q;
          out_payload_o                <= rdata_q[PAY_W-1:0];
          out_ends_message_o           <= rdata_q[PAY_W];
          last_result_o                <= 1'b0;
          pres_q[sidx][cur_slot_q]     <= 1'b0;
          cnt_q                        <= cnt_q + 1'b1;
          cur_seq_q                    <= cur_seq_q + 1'b1;
          // hold the slot at the top sequence so the ring stays aligned
          if (cur_seq_q[SEQ_W-1:0] != {SEQ_W{1'b1}}) begin
            cur_slot_q <= next_slot;
          end
          state_q <= ST_REL;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_AT(a_start_busy, start_i && !busy_o |=> busy_o, "accepted request did not raise busy")
  `ASSERT_AT(a_run_busy, result_valid_o && !last_result_o |-> busy_o, "run ended without final ack")
  `ASSERT_NEVER(a_data_last, result_valid_o && kind_o == KIND_DATA && last_result_o, "delivered frame marked last")
  `ASSERT_NEVER(a_ack_payload, result_valid_o && kind_o != KIND_DATA && out_payload_o != '0, "ack carries payload")

endmodule
`default_nettype wire

// File: tb/sv/selective_repeat_receive_window_checker.sv
`timescale 1ns / 1ps
// Checker for the selective-repeat receive window: keeps its own per-source windows,
// predicts delivered frames, acks and forwarded acks, and compares every result.
// Depends on srrw_pkg.
module selective_repeat_receive_window_checker #(
  parameter int WINDOW  = 8,
  parameter int SOURCES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic                                 busy_i,
  input  logic                                 cfg_we_i,
  input  logic [0:0]                           cfg_idx_i,
  input  logic [srrw_pkg::OWN_W-1:0]           cfg_wdata_i,
  input  logic [srrw_pkg::SRC_ID_W-1:0]        src_id_i,
  input  logic [srrw_pkg::SEQ_W-1:0]           seq_num_i,
  input  logic                                 crc_ok_i,
  input  logic                                 is_ack_i,
  input  logic [srrw_pkg::SEQ_W-1:0]           ack_in_i,
  input  logic                                 ends_message_i,
  input  logic [srrw_pkg::PAY_W-1:0]           payload_i,
  input  logic                                 result_valid_i,
  input  logic [1:0]                           kind_i,
  input  logic [srrw_pkg::SRC_ID_W-1:0]        peer_id_i,
  input  logic [srrw_pkg::OWN_W-1:0]           sender_id_i,
  input  logic signed [srrw_pkg::NUM_W-1:0]    number_i,
  input  logic [srrw_pkg::PAY_W-1:0]           out_payload_i,
  input  logic                                 out_ends_message_i,
  input  logic                                 last_result_i,
  output int unsigned                          fail_count_o,
  output int unsigned                          due_count_o
);
  import srrw_pkg::*;

  typedef struct {
    kind_e                   kind;
    logic [SRC_ID_W-1:0]     peer;
    logic [OWN_W-1:0]        sender;
    logic signed [NUM_W-1:0] number;
    logic [PAY_W-1:0]        payload;
    logic                    ends;
    logic                    last;
  } frame_result_t;

  logic [WS_W-1:0]    rx_window;
  logic [OWN_W-1:0]   own_id;
  logic [SEQ_W-1:0]   next_seq [SOURCES];
  logic [WINDOW-1:0]  held [SOURCES];
  logic [PAY_W-1:0]   held_payload [SOURCES][WINDOW];
  logic               held_ends [SOURCES][WINDOW];
  frame_result_t      due_results [$];

  function automatic frame_result_t make_result(kind_e kind, logic [SRC_ID_W-1:0] peer,
                                                logic [OWN_W-1:0] sender, int num,
                                                logic [PAY_W-1:0] payload, logic ends,
                                                logic last);
    frame_result_t r;
    r.kind    = kind;
    r.peer    = peer;
    r.sender  = sender;
    r.number  = NUM_W'(num);
    r.payload = payload;
    r.ends    = ends;
    r.last    = last;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [PAY_W-1:0] want,
                                        logic [PAY_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count_o++;
    end
  endfunction

  // Accept one frame into the window of its source and queue what it causes.
  task automatic receive_frame();
    int unsigned src;
    int unsigned span;
    int unsigned first;
    int unsigned run;
    int unsigned s;
    int unsigned slot;
    int unsigned i;
    if (!crc_ok_i) return;
    src = src_id_i;
    if (is_ack_i) begin
      due_results.push_back(make_result(KIND_FWD, src_id_i, '0, int'(ack_in_i), '0,
                                        1'b0, 1'b1));
      return;
    end
    if (src >= SOURCES) return;
    span  = (rx_window > WINDOW) ? WINDOW : rx_window;
    first = next_seq[src];
    if (seq_num_i < first || seq_num_i >= first + span) return;

    slot = seq_num_i % WINDOW;
    held_payload[src][slot] = payload_i;
    held_ends[src][slot]    = ends_message_i;
    held[src][slot]         = 1'b1;

    if (seq_num_i != first) begin
      // ahead of the expected frame: re-ack the last in-order one
      due_results.push_back(make_result(KIND_ACK, src_id_i, own_id, int'(first) - 1, '0,
                                        1'b0, 1'b1));
      return;
    end
    run = 0;
    for (i = 0; i < span; i++) begin
      s = first + i;
      if (s > 32'hFFFF) break;
      slot = s % WINDOW;
      if (!held[src][slot]) break;
      due_results.push_back(make_result(KIND_DATA, src_id_i, '0, int'(s),
                                        held_payload[src][slot], held_ends[src][slot],
                                        1'b0));
      held[src][slot] = 1'b0;
      run++;
    end
    // saturate at the top of the sequence space
    next_seq[src] = (first + run > 32'hFFFF) ? 16'hFFFF : SEQ_W'(first + run);
    due_results.push_back(make_result(KIND_ACK, src_id_i, own_id, int'(first + run) - 1,
                                      '0, 1'b0, 1'b1));
  endtask

  task automatic check_result();
    frame_result_t want;
    if (due_results.size() == 0) begin
      $error("unexpected result: kind %0d peer %0d number %0d", kind_i, peer_id_i,
             number_i);
      fail_count_o++;
      return;
    end
    want = due_results.pop_front();
    compare_field("kind", want.kind, kind_i);
    compare_field("peer_id", want.peer, peer_id_i);
    compare_field("sender_id", want.sender, sender_id_i);
    compare_field("number", $unsigned(want.number), $unsigned(number_i));
    compare_field("out_payload", want.payload, out_payload_i);
    compare_field("out_ends_message", want.ends, out_ends_message_i);
    compare_field("last_result", want.last, last_result_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_window = WS_RESET;
      own_id    = OWN_RESET;
      for (int i = 0; i < SOURCES; i++) begin
        next_seq[i] = '0;
        held[i]     = '0;
      end
      due_results.delete();
      fail_count_o = 0;
      due_count_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WINDOW_SIZE: rx_window = cfg_wdata_i[WS_W-1:0];
          CFG_OWN_ID:      own_id = cfg_wdata_i;
          default: ;
        endcase
      end
      // a result never belongs to the request accepted at the same edge
      if (result_valid_i) check_result();
      if (start_i && !busy_i) receive_frame();
      due_count_o = due_results.size();
    end
  end

endmodule

// File: tb/sv/selective_repeat_receive_window_top_test.sv
`timescale 1ns / 1ps
// Testbench top for the selective-repeat receive window: drives frames and register
// writes, and gives the verdict from the checker's failure count.
// Depends on srrw_pkg, selective_repeat_receive_window_top and the checker.
module selective_repeat_receive_window_top_test;
  import srrw_pkg::*;

  localparam int WINDOW        = 8;
  localparam int SOURCES       = 16;
  localparam int PHASE_ITEMS   = 24;
  localparam int SETTLE_CYCLES = 24;
  localparam int QUIET_LIMIT   = 4000;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start;
  logic                       busy;
  logic                       cfg_we;
  logic [0:0]                 cfg_idx;
  logic [OWN_W-1:0]           cfg_wdata;
  logic [SRC_ID_W-1:0]        src_id;
  logic [SEQ_W-1:0]           seq_num;
  logic                       crc_ok;
  logic                       is_ack;
  logic [SEQ_W-1:0]           ack_in;
  logic                       ends_message;
  logic [PAY_W-1:0]           payload;
  logic                       result_valid;
  logic [1:0]                 kind;
  logic [SRC_ID_W-1:0]        peer_id;
  logic [OWN_W-1:0]           sender_id;
  logic signed [NUM_W-1:0]    number;
  logic [PAY_W-1:0]           out_payload;
  logic                       out_ends_message;
  logic                       last_result;
  int unsigned                fail_count;
  int unsigned                due_count;
  int unsigned                idle_pct;
  int unsigned                quiet_cycles;
  logic [SEQ_W-1:0]           cursor [SOURCES];  // next in-order sequence per source

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  selective_repeat_receive_window_top #(.WINDOW(WINDOW), .SOURCES(SOURCES)) dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .start_i            (start),
    .busy_o             (busy),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .src_id_i           (src_id),
    .seq_num_i          (seq_num),
    .crc_ok_i           (crc_ok),
    .is_ack_i           (is_ack),
    .ack_in_i           (ack_in),
    .ends_message_i     (ends_message),
    .payload_i          (payload),
    .result_valid_o     (result_valid),
    .kind_o             (kind),
    .peer_id_o          (peer_id),
    .sender_id_o        (sender_id),
    .number_o           (number),
    .out_payload_o      (out_payload),
    .out_ends_message_o (out_ends_message),
    .last_result_o      (last_result)
  );

  selective_repeat_receive_window_checker #(.WINDOW(WINDOW), .SOURCES(SOURCES)) chk (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .start_i            (start),
    .busy_i             (busy),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .src_id_i           (src_id),
    .seq_num_i          (seq_num),
    .crc_ok_i           (crc_ok),
    .is_ack_i           (is_ack),
    .ack_in_i           (ack_in),
    .ends_message_i     (ends_message),
    .payload_i          (payload),
    .result_valid_i     (result_valid),
    .kind_i             (kind),
    .peer_id_i          (peer_id),
    .sender_id_i        (sender_id),
    .number_i           (number),
    .out_payload_i      (out_payload),
    .out_ends_message_i (out_ends_message),
    .last_result_i      (last_result),
    .fail_count_o       (fail_count),
    .due_count_o        (due_count)
  );

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || result_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [PAY_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Present one request and hold it until accepted; called and returns at a falling edge.
  task automatic send_frame(input logic [SRC_ID_W-1:0] src, input logic [SEQ_W-1:0] seq,
                            input logic ok, input logic ack, input logic [SEQ_W-1:0] ackn,
                            input logic ends, input logic [PAY_W-1:0] pay);
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    src_id       = src;
    seq_num      = seq;
    crc_ok       = ok;
    is_ack       = ack;
    ack_in       = ackn;
    ends_message = ends;
    payload      = pay;
    start        = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic data_frame(input logic [SRC_ID_W-1:0] src, input logic [SEQ_W-1:0] seq,
                            input logic [PAY_W-1:0] pay, input logic ends);
    send_frame(src, seq, 1'b1, 1'b0, SEQ_W'($urandom), ends, pay);
  endtask

  task automatic ack_frame(input logic [SRC_ID_W-1:0] src, input logic [SEQ_W-1:0] ackn);
    send_frame(src, SEQ_W'($urandom), 1'b1, 1'b1, ackn, 1'($urandom), rand_word());
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [OWN_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_results();
    while (due_count != 0 || busy) @(negedge clk);
  endtask

  // Drain, then give a frame that causes nothing time to finish.
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Frames that must leave the window untouched.
  task automatic line_noise(input logic [SRC_ID_W-1:0] src, input int unsigned span);
    case ($urandom_range(0, 3))
      0: ack_frame(SRC_ID_W'($urandom), SEQ_W'($urandom));
      1: send_frame(SRC_ID_W'($urandom), SEQ_W'($urandom), 1'b0, 1'($urandom),
                    SEQ_W'($urandom), 1'($urandom), rand_word());
      2: data_frame(src, cursor[src] + SEQ_W'(span + $urandom_range(0, 200)), rand_word(),
                    1'($urandom));
      default: begin
        if (cursor[src] != 0)
          data_frame(src, cursor[src] - 1'b1 - SEQ_W'($urandom_range(0, cursor[src] - 1)),
                     rand_word(), 1'($urandom));
        else
          ack_frame(src, SEQ_W'($urandom));
      end
    endcase
  endtask

  // One full window of a source in shuffled order, with losses, repeats and noise.
  task automatic window_burst(input logic [SRC_ID_W-1:0] src, input int unsigned span,
                              inout int unsigned count);
    logic [SEQ_W-1:0] order [$];
    logic [SEQ_W-1:0] swap;
    int unsigned      j;
    int unsigned      k;
    for (j = 0; j < span; j++) order.push_back(cursor[src] + SEQ_W'(j));
    for (j = span - 1; j > 0; j--) begin
      k        = $urandom_range(0, j);
      swap     = order[j];
      order[j] = order[k];
      order[k] = swap;
    end
    for (j = 0; j < span; j++) begin
      // lost copy first, retransmission right behind it
      if ($urandom_range(0, 5) == 0)
        send_frame(src, order[j], 1'b0, 1'b0, SEQ_W'($urandom), 1'($urandom), rand_word());
      data_frame(src, order[j], rand_word(), 1'($urandom));
      count++;
      if ($urandom_range(0, 7) == 0) data_frame(src, order[j], rand_word(), 1'($urandom));
      if ($urandom_range(0, 5) == 0) line_noise(src, span);
    end
    cursor[src] += SEQ_W'(span);
  endtask

  logic [WS_W-1:0] ws_plan [6] = '{4'd8, 4'd1, 4'd15, 4'd3, 4'd8, 4'd6};

  initial begin
    int unsigned phase;
    int unsigned count;
    int unsigned span;
    int unsigned j;
    start        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_WINDOW_SIZE;
    cfg_wdata    = '0;
    src_id       = '0;
    seq_num      = '0;
    crc_ok       = 1'b0;
    is_ack       = 1'b0;
    ack_in       = '0;
    ends_message = 1'b0;
    payload      = '0;
    idle_pct     = 0;
    for (j = 0; j < SOURCES; j++) cursor[j] = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: window edges, lost and repeated frames, full release run
    write_reg(CFG_OWN_ID, 8'hFF);
    write_reg(CFG_WINDOW_SIZE, {4'($urandom), 4'd8});
    data_frame(4'd3, 16'd1, '1, 1'b1);              // ahead with expected 0: ack of -1
    send_frame(4'd3, 16'd0, 1'b0, 1'b0, 16'hFFFF, 1'b1, '1);
    send_frame(4'd7, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 1'b0, '0);
    ack_frame(4'd15, 16'hFFFF);
    ack_frame(4'd0, 16'h0000);
    data_frame(4'd3, 16'd8, rand_word(), 1'b0);     // one past the window
    data_frame(4'd3, 16'd2, '0, 1'b0);
    data_frame(4'd3, 16'd2, rand_word(), 1'b1);     // overwrite the buffered copy
    data_frame(4'd3, 16'd7, rand_word(), 1'b0);
    data_frame(4'd3, 16'd0, rand_word(), 1'b1);
    data_frame(4'd3, 16'd4, rand_word(), 1'b0);
    data_frame(4'd3, 16'd5, rand_word(), 1'b1);
    data_frame(4'd3, 16'd6, rand_word(), 1'b0);
    data_frame(4'd3, 16'd3, rand_word(), 1'b1);
    data_frame(4'd3, 16'd7, rand_word(), 1'b0);     // below the window
    for (j = 7; j > 0; j--) data_frame(4'd5, SEQ_W'(j), rand_word(), 1'($urandom));
    data_frame(4'd5, 16'd0, rand_word(), 1'b1);
    cursor[3] = 16'd8;
    cursor[5] = 16'd8;
    settle();
    write_reg(CFG_WINDOW_SIZE, {4'($urandom), 4'd0});
    data_frame(4'd4, 16'd0, rand_word(), 1'b1);      // closed window drops every data frame
    ack_frame(4'd4, 16'h1234);

    for (phase = 0; phase < 6; phase++) begin
      settle();
      idle_pct = (phase < 2) ? 12 : (phase < 4) ? 83 : 0;
      write_reg(CFG_WINDOW_SIZE, {4'($urandom), ws_plan[phase]});
      write_reg(CFG_OWN_ID, (phase == 0) ? 8'h00 : OWN_W'($urandom));
      span  = (ws_plan[phase] > WINDOW) ? WINDOW : ws_plan[phase];
      count = 0;
      while (count < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          ack_frame(SRC_ID_W'($urandom), SEQ_W'($urandom));
          count++;
        end else begin
          window_burst(SRC_ID_W'($urandom), span, count);
        end
        if ($urandom_range(0, 9) == 0) wait_results();
      end
    end

    // top of the sequence space lies far outside every window
    settle();
    idle_pct = 0;
    data_frame(4'd15, 16'hFFFF, rand_word(), 1'b0);
    data_frame(4'd15, 16'hFFFE, '1, 1'b1);
    ack_frame(4'd15, 16'hFFFF);

    settle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
